@@ hw/rtl/atrf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrf_pkg
// Types, constants and the control store of the transmit-request framer.
// ----------------------------------------------------------------------------
package atrf_pkg;

  localparam int unsigned StepW = 5;

  localparam logic [StepW-1:0] StepIdle   = 5'd0;
  localparam logic [StepW-1:0] StepHdrEnd = 5'd17;
  localparam logic [StepW-1:0] StepData   = 5'd18;
  localparam logic [StepW-1:0] StepCsum   = 5'd19;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] FrameType  = 8'h10;
  localparam logic [7:0] AddrHigh   = 8'hFF;
  localparam logic [7:0] AddrLow    = 8'hFE;
  localparam logic [7:0] LenBase    = 8'd14;
  localparam logic [7:0] HdrSumInit = 8'h0D;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_LEN   = 2'd1,
    SRC_DATA  = 2'd2,
    SRC_CSUM  = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    LOR_NONE   = 2'd0,
    LOR_ALWAYS = 2'd1,
    LOR_NLAST  = 2'd2
  } lor_e;

  typedef enum logic [2:0] {
    JC_NEXT  = 3'd0,
    JC_GOTO  = 3'd1,
    JC_EMPTY = 3'd2,
    JC_NLAST = 3'd3,
    JC_START = 3'd4
  } jc_e;

  typedef struct packed {
    logic             emit;
    src_e             src;
    logic [7:0]       konst;
    lor_e             lor;
    logic             fend;
    jc_e              jc;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic empty;
    logic last;
    logic in_frame;
  } cond_t;

  function automatic ctrl_t cw(input logic emit, input src_e src, input logic [7:0] konst,
                               input lor_e lor, input logic fend, input jc_e jc,
                               input logic [StepW-1:0] target);
    ctrl_t c;
    c.emit   = emit;
    c.src    = src;
    c.konst  = konst;
    c.lor    = lor;
    c.fend   = fend;
    c.jc     = jc;
    c.target = target;
    return c;
  endfunction

  function automatic ctrl_t step_rom(input logic [StepW-1:0] a);
    ctrl_t c;
    unique case (a) inside
      StepIdle:   c = cw(1'b0, SRC_CONST, 8'h00, LOR_NONE, 1'b0, JC_START, StepData);
      5'd1:       c = cw(1'b1, SRC_CONST, StartDelim, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      5'd3:       c = cw(1'b1, SRC_LEN, 8'h00, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      5'd4:       c = cw(1'b1, SRC_CONST, FrameType, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      5'd14:      c = cw(1'b1, SRC_CONST, AddrHigh, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      5'd15:      c = cw(1'b1, SRC_CONST, AddrLow, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      5'd2, [5'd5:5'd13], 5'd16:
                  c = cw(1'b1, SRC_CONST, 8'h00, LOR_NONE, 1'b0, JC_NEXT, StepIdle);
      StepHdrEnd: c = cw(1'b1, SRC_CONST, 8'h00, LOR_NONE, 1'b0, JC_EMPTY, StepCsum);
      StepData:   c = cw(1'b1, SRC_DATA, 8'h00, LOR_NLAST, 1'b0, JC_NLAST, StepIdle);
      StepCsum:   c = cw(1'b1, SRC_CSUM, 8'h00, LOR_ALWAYS, 1'b1, JC_GOTO, StepIdle);
      default:    c = cw(1'b0, SRC_CONST, 8'h00, LOR_NONE, 1'b0, JC_GOTO, StepIdle);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/atrf_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrf_in_if
// Payload byte channel into the framer.
// ----------------------------------------------------------------------------
interface atrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] payload_length;
  logic       last_byte;
  logic       empty_frame;

  modport source (output valid, data_byte, payload_length, last_byte, empty_frame,
                  input ready);
  modport sink   (input valid, data_byte, payload_length, last_byte, empty_frame,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/atrf_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrf_out_if
// Serialized frame byte channel out of the framer.
// ----------------------------------------------------------------------------
interface atrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, out_byte, last_of_run, frame_end, input ready);
  modport sink   (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/atrf_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrf_seq
// Step counter and control store; issues one control word per step.
// ----------------------------------------------------------------------------
module atrf_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire atrf_pkg::cond_t cond_i,
  output atrf_pkg::ctrl_t     ctrl_o,
  output logic                idle_o
);
  import atrf_pkg::*;

  logic [StepW-1:0] pc_q, pc_d, pc_inc;
  ctrl_t            c;

  assign c      = step_rom(pc_q);
  assign pc_inc = pc_q + StepW'(1);
  assign ctrl_o = c;
  assign idle_o = (pc_q == StepIdle);

  always_comb begin
    pc_d = pc_q;
    if (cond_i.go) begin
      case (c.jc)
        JC_NEXT:  pc_d = pc_inc;
        JC_GOTO:  pc_d = c.target;
        JC_EMPTY: pc_d = cond_i.empty ? c.target : pc_inc;
        JC_NLAST: pc_d = cond_i.last ? pc_inc : c.target;
        JC_START: begin
          if (cond_i.in_frame) begin
            pc_d = cond_i.empty ? pc_q : c.target;
          end else begin
            pc_d = pc_inc;
          end
        end
        default:  pc_d = StepIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/api_transmit_request_framer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// api_transmit_request_framer_unit
// Wraps a payload byte stream in an API transmit-request frame with checksum.
// ----------------------------------------------------------------------------
// An item is taken only while the step counter rests at idle, then
// the control store issues one output byte per cycle while the output
// register is free. A byte inside an open frame emits its data byte, then
// the checksum when it carries the last-byte flag; the item that opens a
// frame emits the header first, an empty-frame request emits the header
// and checksum, and an empty-frame request inside an open frame is dropped.
// Output backpressure stalls the sequence. The checksum is 0xFF minus
// the low byte of the sum of all bytes after the length field.
module api_transmit_request_framer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  atrf_in_if.sink   req_i,
  atrf_out_if.source frm_o
);
  import atrf_pkg::*;

  ctrl_t      ctrl;
  cond_t      cond;
  logic       idle;
  logic       accept, slot_free, load;

  logic [7:0] data_q, plen_q;
  logic       last_q, empty_q;
  logic       in_frame_q, in_frame_d;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       lor_q, lor_d;
  logic       fend_q;

  assign req_i.ready = idle;
  assign accept      = req_i.valid & idle;
  assign slot_free   = ~out_valid_q | frm_o.ready;
  assign load        = ctrl.emit & slot_free;

  assign cond.go       = ctrl.emit ? slot_free : accept;
  assign cond.empty    = idle ? req_i.empty_frame : empty_q;
  assign cond.last     = last_q;
  assign cond.in_frame = in_frame_q;

  atrf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl),
    .idle_o (idle)
  );

  always_comb begin
    case (ctrl.src)
      SRC_CONST: out_byte_d = ctrl.konst;
      SRC_LEN:   out_byte_d = empty_q ? LenBase : LenBase + plen_q;
      SRC_DATA:  out_byte_d = data_q;
      SRC_CSUM:  out_byte_d = ~sum_q;
      default:   out_byte_d = ctrl.konst;
    endcase
    case (ctrl.lor)
      LOR_NONE:   lor_d = 1'b0;
      LOR_ALWAYS: lor_d = 1'b1;
      LOR_NLAST:  lor_d = ~last_q;
      default:    lor_d = 1'b0;
    endcase
  end

  always_comb begin
    sum_d      = sum_q;
    in_frame_d = in_frame_q;
    if (load && ctrl.src == SRC_DATA) begin
      sum_d      = sum_q + data_q;
      in_frame_d = 1'b1;
    end else if (load && ctrl.src == SRC_CSUM) begin
      sum_d      = HdrSumInit;
      in_frame_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & ~frm_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      sum_q       <= HdrSumInit;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= req_i.data_byte;
      plen_q  <= req_i.payload_length;
      last_q  <= req_i.last_byte;
      empty_q <= req_i.empty_frame;
    end
    if (load) begin
      out_byte_q <= out_byte_d;
      lor_q      <= lor_d;
      fend_q     <= ctrl.fend;
    end
  end

  assign frm_o.valid       = out_valid_q;
  assign frm_o.out_byte    = out_byte_q;
  assign frm_o.last_of_run = lor_q;
  assign frm_o.frame_end   = fend_q;

  a_fend_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm_o.valid && frm_o.frame_end) |-> frm_o.last_of_run)
    else $error("checksum byte not marked as end of run");

  a_ignore_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.empty_frame && in_frame_q) |=> (req_i.ready && in_frame_q))
    else $error("empty request inside open frame not dropped");

  a_sum_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle && !in_frame_q) |-> (sum_q == HdrSumInit))
    else $error("running sum not at header value between frames");

  a_csum_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ctrl.src == SRC_CSUM) |=> (!in_frame_q && idle))
    else $error("frame still open after checksum");

endmodule
`default_nettype wire
